FILE: src/ssb_pkg.sv
// shared types, constants and helpers of the scaled sprite blitter
// used by ssb_sheet and scaled_sprite_blit_pixel, no dependencies
`default_nettype none

package ssb_pkg;

   // default geometry of the sheet and the framebuffer
   localparam int DEF_SHEET_SIZE = 256;
   localparam int DEF_FB_WIDTH   = 256;
   localparam int DEF_FB_HEIGHT  = 256;

   localparam int COLOR_W = 24;
   localparam int FRAC_W  = 16;
   // linear sheet offset before wrapping: base + row * pitch + column
   localparam int LIN_W   = 30;

   // item kinds
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_DRAW = 1'b1;

   // register indexes
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_CLIP_LEFT   = 3'd0;
   localparam csr_index_type CSR_CLIP_RIGHT  = 3'd1;
   localparam csr_index_type CSR_CLIP_TOP    = 3'd2;
   localparam csr_index_type CSR_CLIP_BOTTOM = 3'd3;
   localparam csr_index_type CSR_COLOR_KEY   = 3'd4;
   localparam csr_index_type CSR_SHEET_PITCH = 3'd5;

   // sheet port control
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } sheet_ctl_type;

   // mirror an offset inside a size, saturating at 0 past the edge
   function automatic logic [10:0] mirror_off(input logic [9:0] off, input logic [10:0] size);
      logic [10:0] diff;
      diff = size - {1'b0, off} - 11'd1;
      return ({1'b0, off} < size) ? diff : 11'd0;
   endfunction

endpackage

`default_nettype wire

FILE: src/ssb_sheet.sv
// sprite-sheet memory with wrap of the linear offset into the sheet
// depends on ssb_pkg
`default_nettype none

module ssb_sheet #(
   parameter int SHEET_SIZE = ssb_pkg::DEF_SHEET_SIZE
) (
   input  wire logic                         clock,
   input  wire ssb_pkg::sheet_ctl_type       ctl,
   input  wire logic [$clog2(SHEET_SIZE * SHEET_SIZE):0] offset,
   input  wire logic [ssb_pkg::COLOR_W-1:0]  wr_data,
   output logic      [ssb_pkg::COLOR_W-1:0]  rd_data
);
   import ssb_pkg::*;

   localparam int SheetWords = SHEET_SIZE * SHEET_SIZE;
   localparam int AddrW      = $clog2(SheetWords);
   localparam logic [AddrW:0] WordsLim = (AddrW + 1)'(SheetWords);

   logic [COLOR_W-1:0] mem [SheetWords];
   logic [COLOR_W-1:0] rd_ff;
   logic [AddrW:0]     offset_less;
   logic [AddrW-1:0]   addr;

   // offset arrives below twice the sheet size: one conditional subtract
   always_comb begin
      offset_less = offset - WordsLim;
      addr = (offset >= WordsLim) ? offset_less[AddrW-1:0] : offset[AddrW-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_ff <= mem[addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

FILE: src/scaled_sprite_blit_pixel.sv
// scaled sprite blitter top level: seven-stage pipeline, one item per cycle while rsp_ready is high
// throughput: 1 item per cycle, loads and draws mixed freely; each stage holds its item on stall
// reset: synchronous, clears stage valid bits and the clip, key and pitch registers
// the sheet memory is not cleared; an entry reads correctly once it has been loaded
// depends on ssb_pkg and ssb_sheet
`default_nettype none

module scaled_sprite_blit_pixel #(
   parameter int SHEET_SIZE = ssb_pkg::DEF_SHEET_SIZE,
   parameter int FB_WIDTH   = ssb_pkg::DEF_FB_WIDTH,
   parameter int FB_HEIGHT  = ssb_pkg::DEF_FB_HEIGHT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // input items
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_mode,
   input  wire logic [15:0]                  req_sheet_addr,
   input  wire logic [ssb_pkg::COLOR_W-1:0]  req_load_color,
   input  wire logic signed [11:0]           req_dest_x,
   input  wire logic signed [11:0]           req_dest_y,
   input  wire logic [9:0]                   req_offset_x,
   input  wire logic [9:0]                   req_offset_y,
   input  wire logic [10:0]                  req_scaled_width,
   input  wire logic [10:0]                  req_scaled_height,
   input  wire logic [24:0]                  req_x_ratio,
   input  wire logic [24:0]                  req_y_ratio,
   input  wire logic [1:0]                   req_flip,
   // result items
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_write_enable,
   output logic [15:0]                       rsp_fb_addr,
   output logic [ssb_pkg::COLOR_W-1:0]       rsp_pixel_color,
   // register writes
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire ssb_pkg::csr_index_type       csr_index,
   input  wire logic [ssb_pkg::COLOR_W-1:0]  csr_data
);
   import ssb_pkg::*;

   localparam int SheetWords = SHEET_SIZE * SHEET_SIZE;
   localparam int AddrW      = $clog2(SheetWords);
   // quotient estimate width, reciprocal for the wrap of the linear offset
   localparam int QuotW      = LIN_W - AddrW + 1;
   localparam logic [QuotW-1:0] Recip = QuotW'((longint'(1) << LIN_W) / SheetWords);
   localparam int ProdW      = LIN_W + QuotW;
   localparam logic signed [11:0] FbWidthS  = 12'(FB_WIDTH);
   localparam logic signed [11:0] FbHeightS = 12'(FB_HEIGHT);

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [8:0]         clip_left_ff, clip_right_ff, clip_top_ff, clip_bottom_ff;
   logic [8:0]         sheet_pitch_ff;
   logic [COLOR_W-1:0] color_key_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= 9'd0;
         clip_right_ff  <= 9'd256;
         clip_top_ff    <= 9'd0;
         clip_bottom_ff <= 9'd256;
         color_key_ff   <= '0;
         sheet_pitch_ff <= 9'd256;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CLIP_LEFT:   clip_left_ff   <= csr_data[8:0];
            CSR_CLIP_RIGHT:  clip_right_ff  <= csr_data[8:0];
            CSR_CLIP_TOP:    clip_top_ff    <= csr_data[8:0];
            CSR_CLIP_BOTTOM: clip_bottom_ff <= csr_data[8:0];
            CSR_COLOR_KEY:   color_key_ff   <= csr_data;
            CSR_SHEET_PITCH: sheet_pitch_ff <= csr_data[8:0];
            default: ;  // unknown index ignored
         endcase
      end
   end

   // ---------------------------------------------------------------
   // stage valid bits and enables: a stage loads when it is empty or
   // its item moves on, so bubbles are squeezed out on a stall
   // ---------------------------------------------------------------
   logic [7:1] v_ff, v_in;
   logic [7:1] en;

   always_comb begin
      en[7] = !v_ff[7] | rsp_ready;
      for (int k = 6; k >= 1; k--) begin
         en[k] = !v_ff[k] | en[k+1];
      end
   end

   always_comb begin
      v_in = v_ff;
      if (en[1]) begin
         v_in[1] = req_valid;
      end
      for (int k = 2; k <= 7; k++) begin
         if (en[k]) begin
            v_in[k] = v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = en[1];

   // ---------------------------------------------------------------
   // stage 1: mirror the offsets, clip and framebuffer window test
   // ---------------------------------------------------------------
   logic               mode1_ff, mode1_in;
   logic [15:0]        base1_ff, base1_in;
   logic [10:0]        ox1_ff, ox1_in, oy1_ff, oy1_in;
   logic [24:0]        xr1_ff, xr1_in, yr1_ff, yr1_in;
   logic               in1_ff, in1_in;
   logic [10:0]        dx1_ff, dx1_in, dy1_ff, dy1_in;
   logic [COLOR_W-1:0] color1_ff, color1_in;
   logic               in_x, in_y;

   always_comb begin
      mode1_in  = req_mode;
      base1_in  = req_sheet_addr;
      ox1_in    = req_flip[0] ? mirror_off(req_offset_x, req_scaled_width)
                              : {1'b0, req_offset_x};
      oy1_in    = req_flip[1] ? mirror_off(req_offset_y, req_scaled_height)
                              : {1'b0, req_offset_y};
      xr1_in    = req_x_ratio;
      yr1_in    = req_y_ratio;
      // the framebuffer bounds hold even when the clip window reaches past them
      in_x = !req_dest_x[11] && (req_dest_x < FbWidthS)
             && (req_dest_x >= $signed({3'b000, clip_left_ff}))
             && (req_dest_x <  $signed({3'b000, clip_right_ff}));
      in_y = !req_dest_y[11] && (req_dest_y < FbHeightS)
             && (req_dest_y >= $signed({3'b000, clip_top_ff}))
             && (req_dest_y <  $signed({3'b000, clip_bottom_ff}));
      in1_in    = in_x && in_y;
      dx1_in    = req_dest_x[10:0];
      dy1_in    = req_dest_y[10:0];
      color1_in = req_load_color;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         mode1_ff  <= mode1_in;
         base1_ff  <= base1_in;
         ox1_ff    <= ox1_in;
         oy1_ff    <= oy1_in;
         xr1_ff    <= xr1_in;
         yr1_ff    <= yr1_in;
         in1_ff    <= in1_in;
         dx1_ff    <= dx1_in;
         dy1_ff    <= dy1_in;
         color1_ff <= color1_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: 9.16 scaling, truncated to the source pixel below, framebuffer index
   // ---------------------------------------------------------------
   logic               mode2_ff, mode2_in;
   logic [15:0]        base2_ff, base2_in;
   logic [19:0]        col2_ff, col2_in, row2_ff, row2_in;
   logic               in2_ff, in2_in;
   logic [15:0]        fb2_ff, fb2_in;
   logic [COLOR_W-1:0] color2_ff, color2_in;
   logic [35:0]        col_prod, row_prod;
   logic [31:0]        fb_lin;

   always_comb begin
      col_prod  = 36'(ox1_ff) * 36'(xr1_ff);
      row_prod  = 36'(oy1_ff) * 36'(yr1_ff);
      col2_in   = col_prod[35:FRAC_W];
      row2_in   = row_prod[35:FRAC_W];
      // only meaningful for pixels inside the window, low 16 bits kept
      fb_lin    = 32'(dy1_ff) * 32'(FB_WIDTH) + 32'(dx1_ff);
      fb2_in    = fb_lin[15:0];
      mode2_in  = mode1_ff;
      base2_in  = base1_ff;
      in2_in    = in1_ff;
      color2_in = color1_ff;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         mode2_ff  <= mode2_in;
         base2_ff  <= base2_in;
         col2_ff   <= col2_in;
         row2_ff   <= row2_in;
         in2_ff    <= in2_in;
         fb2_ff    <= fb2_in;
         color2_ff <= color2_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: linear sheet offset, a load uses its address as is
   // ---------------------------------------------------------------
   logic               mode3_ff, mode3_in;
   logic [LIN_W-1:0]   lin3_ff, lin3_in;
   logic               in3_ff, in3_in;
   logic [15:0]        fb3_ff, fb3_in;
   logic [COLOR_W-1:0] color3_ff, color3_in;

   always_comb begin
      if (mode2_ff == MODE_LOAD) begin
         lin3_in = LIN_W'(base2_ff);
      end else begin
         lin3_in = LIN_W'(base2_ff) + LIN_W'(row2_ff) * LIN_W'(sheet_pitch_ff)
                   + LIN_W'(col2_ff);
      end
      mode3_in  = mode2_ff;
      in3_in    = in2_ff;
      fb3_in    = fb2_ff;
      color3_in = color2_ff;
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         mode3_ff  <= mode3_in;
         lin3_ff   <= lin3_in;
         in3_ff    <= in3_in;
         fb3_ff    <= fb3_in;
         color3_ff <= color3_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 4: quotient estimate by the sheet size, reciprocal multiply,
   // at most one below the true quotient
   // ---------------------------------------------------------------
   logic               mode4_ff, mode4_in;
   logic [LIN_W-1:0]   lin4_ff, lin4_in;
   logic [QuotW-1:0]   q4_ff, q4_in;
   logic               in4_ff, in4_in;
   logic [15:0]        fb4_ff, fb4_in;
   logic [COLOR_W-1:0] color4_ff, color4_in;
   logic [ProdW-1:0]   q_prod;

   always_comb begin
      q_prod    = ProdW'(lin3_ff) * ProdW'(Recip);
      q4_in     = q_prod[ProdW-1:LIN_W];
      lin4_in   = lin3_ff;
      mode4_in  = mode3_ff;
      in4_in    = in3_ff;
      fb4_in    = fb3_ff;
      color4_in = color3_ff;
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         mode4_ff  <= mode4_in;
         lin4_ff   <= lin4_in;
         q4_ff     <= q4_in;
         in4_ff    <= in4_in;
         fb4_ff    <= fb4_in;
         color4_ff <= color4_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 5: partial remainder, below twice the sheet size
   // ---------------------------------------------------------------
   logic               mode5_ff, mode5_in;
   logic [AddrW:0]     r5_ff, r5_in;
   logic               in5_ff, in5_in;
   logic [15:0]        fb5_ff, fb5_in;
   logic [COLOR_W-1:0] color5_ff, color5_in;
   logic [LIN_W-1:0]   rem;

   always_comb begin
      rem       = lin4_ff - LIN_W'(q4_ff) * LIN_W'(SheetWords);
      r5_in     = rem[AddrW:0];
      mode5_in  = mode4_ff;
      in5_in    = in4_ff;
      fb5_in    = fb4_ff;
      color5_in = color4_ff;
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         mode5_ff  <= mode5_in;
         r5_ff     <= r5_in;
         in5_ff    <= in5_in;
         fb5_ff    <= fb5_in;
         color5_ff <= color5_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 6: sheet access, final wrap inside the sheet module; loads
   // write and draws read in item order, so a draw sees every earlier load
   // ---------------------------------------------------------------
   logic               mode6_ff, mode6_in;
   logic               in6_ff, in6_in;
   logic [15:0]        fb6_ff, fb6_in;
   logic [COLOR_W-1:0] rd_color;
   sheet_ctl_type      sheet_ctl;

   always_comb begin
      sheet_ctl.wr_en = en[6] && v_ff[5] && (mode5_ff == MODE_LOAD);
      sheet_ctl.rd_en = en[6] && v_ff[5] && (mode5_ff == MODE_DRAW);
      mode6_in = mode5_ff;
      in6_in   = in5_ff;
      fb6_in   = fb5_ff;
   end

   ssb_sheet #(
      .SHEET_SIZE(SHEET_SIZE)
   ) u_sheet (
      .clock   (clock),
      .ctl     (sheet_ctl),
      .offset  (r5_ff),
      .wr_data (color5_ff),
      .rd_data (rd_color)
   );

   always_ff @(posedge clock) begin
      if (en[6]) begin
         mode6_ff <= mode6_in;
         in6_ff   <= in6_in;
         fb6_ff   <= fb6_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 7: colour key and output register
   // ---------------------------------------------------------------
   logic               we7_ff, we7_in;
   logic [15:0]        fb7_ff, fb7_in;
   logic [COLOR_W-1:0] color7_ff, color7_in;

   always_comb begin
      // loads, keyed pixels and clipped pixels give an all-zero result
      we7_in    = (mode6_ff == MODE_DRAW) && in6_ff && (rd_color != color_key_ff);
      fb7_in    = we7_in ? fb6_ff : '0;
      color7_in = we7_in ? rd_color : '0;
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         we7_ff    <= we7_in;
         fb7_ff    <= fb7_in;
         color7_ff <= color7_in;
      end
   end

   assign rsp_valid        = v_ff[7];
   assign rsp_write_enable = we7_ff;
   assign rsp_fb_addr      = fb7_ff;
   assign rsp_pixel_color  = color7_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // a result without a write carries zero address and colour
   a_quiet_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_fb_addr == '0 && rsp_pixel_color == '0)
      else $error("result without write carries nonzero payload");

   // a load never turns into a framebuffer write
   a_load_no_write: assert property (@(posedge clock) disable iff (reset)
      v_ff[6] && (mode6_ff == MODE_LOAD) && en[7] |=> !rsp_write_enable)
      else $error("load item produced a framebuffer write");

   // the partial remainder stays below twice the sheet size
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      v_ff[5] |-> {1'b0, r5_ff} < (AddrW + 2)'(2 * SheetWords))
      else $error("sheet offset remainder out of range");

   // an accepted item occupies the first stage on the next cycle
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v_ff[1])
      else $error("accepted item lost at pipeline entry");

endmodule

`default_nettype wire

FILE: bench/tb_scaled_sprite_blit_pixel.sv
// self-checking bench for scaled_sprite_blit_pixel: directed table, then random sprite jobs, stray draws and loads
// predicts every result item in-bench or takes it from the table, and compares against the rsp channel in order
// depends on ssb_pkg and the scaled_sprite_blit_pixel rtl
module tb_scaled_sprite_blit_pixel;
   timeunit 1ns;
   timeprecision 1ps;

   import ssb_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 5;
   localparam int DRAIN_CYCLES   = 12;    // pipeline is seven deep, plus some margin
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on any channel
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 212;
   localparam int NUM_DIRECTED   = 20;
   localparam int MAX_REPORTS    = 10;

   localparam int FB_W = DEF_FB_WIDTH;
   localparam int FB_H = DEF_FB_HEIGHT;

   // 9.16 step ratios
   localparam logic [24:0] UNIT_RATIO = 25'h0010000;
   localparam logic [24:0] MAX_RATIO  = 25'h1FFFFFF;

   // mirror bits
   localparam logic [1:0] FLIP_NONE = 2'b00;
   localparam logic [1:0] FLIP_H    = 2'b01;
   localparam logic [1:0] FLIP_V    = 2'b10;
   localparam logic [1:0] FLIP_HV   = 2'b11;

   // indexes past the register file, which the block must ignore
   localparam csr_index_type CSR_SPARE_A = 3'd6;
   localparam csr_index_type CSR_SPARE_B = 3'd7;

   typedef struct packed {
      logic        mode;
      logic [15:0] sheet_addr;
      logic [23:0] load_color;
      logic [11:0] dest_x;
      logic [11:0] dest_y;
      logic [9:0]  offset_x;
      logic [9:0]  offset_y;
      logic [10:0] scaled_width;
      logic [10:0] scaled_height;
      logic [24:0] x_ratio;
      logic [24:0] y_ratio;
      logic [1:0]  flip;
   } blit_item_type;

   typedef struct packed {
      logic        write_enable;
      logic [15:0] fb_addr;
      logic [23:0] pixel_color;
   } pixel_result_type;

   localparam pixel_result_type NO_WRITE = '0;

   typedef struct packed {
      blit_item_type    item;
      logic             known;   // result typed in below rather than predicted
      pixel_result_type result;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_mode;
   logic [15:0] req_sheet_addr;
   logic [23:0] req_load_color;
   logic [11:0] req_dest_x;
   logic [11:0] req_dest_y;
   logic [9:0]  req_offset_x;
   logic [9:0]  req_offset_y;
   logic [10:0] req_scaled_width;
   logic [10:0] req_scaled_height;
   logic [24:0] req_x_ratio;
   logic [24:0] req_y_ratio;
   logic [1:0]  req_flip;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_write_enable;
   logic [15:0] rsp_fb_addr;
   logic [23:0] rsp_pixel_color;
   logic        csr_valid;
   logic        csr_ready;
   csr_index_type csr_index;
   logic [23:0] csr_data;

   // bench copy of the register file and of the sheet
   logic [8:0]  clip_left, clip_right, clip_top, clip_bottom, sheet_pitch;
   logic [23:0] color_key;
   logic [23:0] sheet_copy [DEF_SHEET_SIZE * DEF_SHEET_SIZE];
   // entries already sent a load, so draws never touch an unwritten word
   bit          sheet_loaded [DEF_SHEET_SIZE * DEF_SHEET_SIZE];

   pixel_result_type pixel_writes_due [$];
   int          items_sent;
   int          mismatches;
   int          burst_left;
   int          quiet_cycles;
   int          rsp_cycle;

   scaled_sprite_blit_pixel u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_sheet_addr    (req_sheet_addr),
      .req_load_color    (req_load_color),
      .req_dest_x        (req_dest_x),
      .req_dest_y        (req_dest_y),
      .req_offset_x      (req_offset_x),
      .req_offset_y      (req_offset_y),
      .req_scaled_width  (req_scaled_width),
      .req_scaled_height (req_scaled_height),
      .req_x_ratio       (req_x_ratio),
      .req_y_ratio       (req_y_ratio),
      .req_flip          (req_flip),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_fb_addr       (rsp_fb_addr),
      .rsp_pixel_color   (rsp_pixel_color),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // directed items, run with the reset register values
   // the first loads fill the words that the draws below read
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      // loads always answer with no write
      '{'{MODE_LOAD, 16'h0000, 24'h123456, 12'h000, 12'h000, 10'd0, 10'd0, 11'd1, 11'd1,
          UNIT_RATIO, UNIT_RATIO, FLIP_NONE}, 1'b1, NO_WRITE},
      '{'{MODE_LOAD, 16'hFFFF, 24'hFFFFFF, 12'hFFF, 12'hFFF, 10'd1023, 10'd1023, 11'h7FF,
          11'h7FF, MAX_RATIO, MAX_RATIO, FLIP_HV}, 1'b1, NO_WRITE},
      // word equal to the reset colour key
      '{'{MODE_LOAD, 16'h0001, 24'h000000, 12'h000, 12'h000, 10'd0, 10'd0, 11'd1, 11'd1,
          UNIT_RATIO, UNIT_RATIO, FLIP_NONE}, 1'b1, NO_WRITE},
      '{'{MODE_LOAD, 16'h0100, 24'hABCDEF, 12'h000, 12'h000, 10'd0, 10'd0, 11'd1, 11'd1,
          UNIT_RATIO, UNIT_RATIO, FLIP_NONE}, 1'b1, NO_WRITE},
      '{'{MODE_LOAD, 16'h0101, 24'h00FF00, 12'h000, 12'h000, 10'd0, 10'd0, 11'd1, 11'd1,
          UNIT_RATIO, UNIT_RATIO, FLIP_NONE}, 1'b1, NO_WRITE},
      // framebuffer corners
      '{'{MODE_DRAW, 16'h0000, 24'h000000, 12'd0, 12'd0, 10'd0, 10'd0, 11'd1, 11'd1,
          UNIT_RATIO, UNIT_RATIO, FLIP_NONE}, 1'b1, '{1'b1, 16'h0000, 24'h123456}},
      '{'{MODE_DRAW, 16'h0000, 24'hFFFFFF, 12'd255, 12'd255, 10'd0, 10'd0, 11'd1, 11'd1,
          UNIT_RATIO, UNIT_RATIO, FLIP_NONE}, 1'b1, '{1'b1, 16'hFFFF, 24'h123456}},
      '{'{MODE_DRAW, 16'hFFFF, 24'h000000, 12'd0, 12'd255, 10'd0, 10'd0, 11'd1, 11'd1,
          UNIT_RATIO, UNIT_RATIO, FLIP_NONE}, 1'b1, '{1'b1, 16'hFF00, 24'hFFFFFF}},
      // just off the framebuffer on the right, left and top, and the coordinate extremes
      '{'{MODE_DRAW, 16'h0000, 24'h000000, 12'd256, 12'd0, 10'd0, 10'd0, 11'd1, 11'd1,
          UNIT_RATIO, UNIT_RATIO, FLIP_NONE}, 1'b1, NO_WRITE},
      '{'{MODE_DRAW, 16'h0000, 24'h000000, 12'hFFF, 12'd0, 10'd0, 10'd0, 11'd1, 11'd1,
          UNIT_RATIO, UNIT_RATIO, FLIP_NONE}, 1'b1, NO_WRITE},
      '{'{MODE_DRAW, 16'h0000, 24'h000000, 12'h800, 12'h7FF, 10'd0, 10'd0, 11'd1, 11'd1,
          UNIT_RATIO, UNIT_RATIO, FLIP_NONE}, 1'b1, NO_WRITE},
      '{'{MODE_DRAW, 16'h0000, 24'h000000, 12'd10, 12'hFFF, 10'd0, 10'd0, 11'd1, 11'd1,
          UNIT_RATIO, UNIT_RATIO, FLIP_NONE}, 1'b1, NO_WRITE},
      // keyed source pixel
      '{'{MODE_DRAW, 16'h0001, 24'h000000, 12'd5, 12'd5, 10'd0, 10'd0, 11'd1, 11'd1,
          UNIT_RATIO, UNIT_RATIO, FLIP_NONE}, 1'b1, NO_WRITE},
      // read address wraps round the end of the sheet
      '{'{MODE_DRAW, 16'hFFFF, 24'h000000, 12'd3, 12'd2, 10'd1, 10'd0, 11'd2, 11'd1,
          UNIT_RATIO, UNIT_RATIO, FLIP_NONE}, 1'b0, NO_WRITE},
      // horizontal and vertical mirror
      '{'{MODE_DRAW, 16'h0100, 24'h000000, 12'd7, 12'd9, 10'd0, 10'd0, 11'd2, 11'd1,
          UNIT_RATIO, UNIT_RATIO, FLIP_H}, 1'b0, NO_WRITE},
      '{'{MODE_DRAW, 16'h0000, 24'h000000, 12'd200, 12'd100, 10'd0, 10'd0, 11'd1, 11'd2,
          UNIT_RATIO, UNIT_RATIO, FLIP_V}, 1'b0, NO_WRITE},
      // offsets past the scaled size: mirror saturates at zero, including a zero size
      '{'{MODE_DRAW, 16'h0000, 24'h000000, 12'd20, 12'd30, 10'd5, 10'd9, 11'd3, 11'd0,
          UNIT_RATIO, UNIT_RATIO, FLIP_HV}, 1'b0, NO_WRITE},
      // zero ratios collapse every offset onto source pixel zero
      '{'{MODE_DRAW, 16'h0000, 24'hFFFFFF, 12'd40, 12'd50, 10'd1023, 10'd1023, 11'd1024,
          11'd1024, 25'd0, 25'd0, FLIP_NONE}, 1'b0, NO_WRITE},
      '{'{MODE_DRAW, 16'h0000, 24'h000000, 12'd60, 12'd70, 10'd1023, 10'd1023, 11'd1024,
          11'd1024, MAX_RATIO, MAX_RATIO, FLIP_HV}, 1'b0, NO_WRITE},
      '{'{MODE_DRAW, 16'h0000, 24'h000000, 12'd80, 12'd90, 10'd0, 10'd0, 11'h7FF, 11'h7FF,
          MAX_RATIO, MAX_RATIO, FLIP_NONE}, 1'b0, NO_WRITE}
   };

   always #(CLK_PERIOD / 2) clock = ~clock;

   // sheet word that a draw reads: mirror, scale, then base + row * pitch + column
   function automatic logic [15:0] sheet_read_addr(input blit_item_type it);
      longint unsigned ox, oy, col, row;
      ox = it.offset_x;
      oy = it.offset_y;
      if (it.flip[0]) ox = (ox + 1 <= it.scaled_width) ? it.scaled_width - 1 - ox : 0;
      if (it.flip[1]) oy = (oy + 1 <= it.scaled_height) ? it.scaled_height - 1 - oy : 0;
      col = (ox * it.x_ratio) >> FRAC_W;
      row = (oy * it.y_ratio) >> FRAC_W;
      return 16'(it.sheet_addr + row * sheet_pitch + col);
   endfunction

   // framebuffer write caused by one item; loads update the sheet copy
   function automatic pixel_result_type blit_pixel(input blit_item_type it);
      pixel_result_type res;
      logic [23:0]      color;
      int               dx, dy;
      res = NO_WRITE;
      if (it.mode == MODE_LOAD) begin
         sheet_copy[it.sheet_addr] = it.load_color;
         return res;
      end
      color = sheet_copy[sheet_read_addr(it)];
      dx = int'($signed(it.dest_x));
      dy = int'($signed(it.dest_y));
      // clip window and framebuffer bounds both apply
      if (color != color_key &&
          dx >= int'(clip_left) && dx < int'(clip_right) &&
          dy >= int'(clip_top) && dy < int'(clip_bottom) &&
          dx >= 0 && dx < FB_W && dy >= 0 && dy < FB_H) begin
         res.write_enable = 1'b1;
         res.fb_addr      = 16'(dy * FB_W + dx);
         res.pixel_color  = color;
      end
      return res;
   endfunction

   // every field at full width
   function automatic blit_item_type random_fields();
      blit_item_type it;
      it.mode          = 1'($urandom_range(0, 1));
      it.sheet_addr    = 16'($urandom);
      it.load_color    = 24'($urandom);
      it.dest_x        = 12'($urandom);
      it.dest_y        = 12'($urandom);
      it.offset_x      = 10'($urandom);
      it.offset_y      = 10'($urandom);
      it.scaled_width  = 11'($urandom);
      it.scaled_height = 11'($urandom);
      it.x_ratio       = 25'($urandom);
      it.y_ratio       = 25'($urandom);
      it.flip          = 2'($urandom);
      return it;
   endfunction

   // load of one sheet word, often with the current key so keyed pixels come up
   function automatic blit_item_type load_item(input logic [15:0] addr);
      blit_item_type it;
      it = random_fields();
      it.mode = MODE_LOAD;
      it.sheet_addr = addr;
      case ($urandom_range(0, 7))
         0, 1: it.load_color = color_key;
         2: it.load_color = 24'h000000;
         3: it.load_color = 24'hFFFFFF;
         default: ;
      endcase
      return it;
   endfunction

   task automatic report_mismatch(input string what, input pixel_result_type want,
                                  input pixel_result_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch (%s): expected we=%0b addr=%h color=%h, got we=%0b addr=%h color=%h",
                  what, want.write_enable, want.fb_addr, want.pixel_color,
                  got.write_enable, got.fb_addr, got.pixel_color);
   endtask

   // hand one item over, then log its expected result; the sender idles between bursts
   task automatic send_item(input blit_item_type it, input logic known,
                            input pixel_result_type typed);
      pixel_result_type due;
      int               gap;
      req_valid         <= 1'b1;
      req_mode          <= it.mode;
      req_sheet_addr    <= it.sheet_addr;
      req_load_color    <= it.load_color;
      req_dest_x        <= it.dest_x;
      req_dest_y        <= it.dest_y;
      req_offset_x      <= it.offset_x;
      req_offset_y      <= it.offset_y;
      req_scaled_width  <= it.scaled_width;
      req_scaled_height <= it.scaled_height;
      req_x_ratio       <= it.x_ratio;
      req_y_ratio       <= it.y_ratio;
      req_flip          <= it.flip;
      do @(posedge clock); while (!req_ready);
      if (it.mode == MODE_LOAD) sheet_loaded[it.sheet_addr] = 1'b1;
      due = blit_pixel(it);
      pixel_writes_due.push_back(known ? typed : due);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 15) : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // draws go out only once the word they read has been loaded
   task automatic send_draw(input blit_item_type it);
      logic [15:0] ra;
      ra = sheet_read_addr(it);
      if (!sheet_loaded[ra]) send_item(load_item(ra), 1'b0, NO_WRITE);
      send_item(it, 1'b0, NO_WRITE);
   endtask

   // register write; valid is lowered by the caller once the whole batch is in
   task automatic write_csr(input csr_index_type idx, input logic [23:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CLIP_LEFT:   clip_left   = data[8:0];
         CSR_CLIP_RIGHT:  clip_right  = data[8:0];
         CSR_CLIP_TOP:    clip_top    = data[8:0];
         CSR_CLIP_BOTTOM: clip_bottom = data[8:0];
         CSR_COLOR_KEY:   color_key   = data;
         CSR_SHEET_PITCH: sheet_pitch = data[8:0];
         default: ;
      endcase
   endtask

   // result side: compare against the oldest expectation, then stall on its own pattern
   always @(posedge clock) begin : result_side
      pixel_result_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_write_enable, rsp_fb_addr, rsp_pixel_color};
         if (pixel_writes_due.size() == 0) begin
            report_mismatch("result with no item outstanding", NO_WRITE, got);
         end else begin
            want = pixel_writes_due.pop_front();
            if (got.write_enable !== want.write_enable || got.fb_addr !== want.fb_addr ||
                got.pixel_color !== want.pixel_color)
               report_mismatch("result fields", want, got);
         end
      end
      // cycle through always ready, coin toss, a fixed duty cycle and rare stalls
      case ((rsp_cycle / 512) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2: rsp_ready <= ((rsp_cycle % 7) < 4);
         default: rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
      rsp_cycle <= rsp_cycle + 1;
   end

   // watchdog: any handshake counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL scaled_sprite_blit_pixel");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      blit_item_type it;
      int          phase, phase_start, r, c, ox, oy, pick;
      int          src_w, src_h, span_w, span_h, dx0, dy0;
      logic [15:0] base;
      logic [1:0]  sprite_flip;
      logic [24:0] step_x, step_y;
      logic [8:0]  new_left, new_right, new_top, new_bottom, new_pitch;
      logic [23:0] new_key;
      logic [14:0] junk;

      // every input known from time zero
      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_mode          = MODE_LOAD;
      req_sheet_addr    = '0;
      req_load_color    = '0;
      req_dest_x        = '0;
      req_dest_y        = '0;
      req_offset_x      = '0;
      req_offset_y      = '0;
      req_scaled_width  = '0;
      req_scaled_height = '0;
      req_x_ratio       = '0;
      req_y_ratio       = '0;
      req_flip          = FLIP_NONE;
      rsp_ready         = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = CSR_CLIP_LEFT;
      csr_data          = '0;
      items_sent        = 0;
      mismatches        = 0;
      quiet_cycles      = 0;
      rsp_cycle         = 0;
      burst_left        = 8;

      // register values after reset
      clip_left   = 9'd0;
      clip_right  = 9'd256;
      clip_top    = 9'd0;
      clip_bottom = 9'd256;
      color_key   = 24'h000000;
      sheet_pitch = 9'd256;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].result);

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            // registers change only with the pipeline empty
            req_valid <= 1'b0;
            while (pixel_writes_due.size() != 0) @(posedge clock);
            repeat (DRAIN_CYCLES) @(posedge clock);
            case (phase)
               1: begin
                  // empty window, all-ones key, zero pitch
                  new_left = 9'd0;  new_right = 9'd0;  new_top = 9'd0;  new_bottom = 9'd0;
                  new_key = 24'hFFFFFF;  new_pitch = 9'd0;
               end
               2: begin
                  // window reaching past the framebuffer, unit pitch
                  new_left = 9'd0;  new_right = 9'd511;  new_top = 9'd0;  new_bottom = 9'd511;
                  new_key = 24'h000000;  new_pitch = 9'd1;
               end
               3: begin
                  new_left   = 9'($urandom_range(0, 64));
                  new_right  = 9'($urandom_range(192, 300));
                  new_top    = 9'($urandom_range(0, 64));
                  new_bottom = 9'($urandom_range(192, 300));
                  new_key    = 24'($urandom);
                  new_pitch  = 9'd511;
               end
               default: begin
                  new_left   = 9'($urandom_range(0, 128));
                  new_right  = 9'($urandom_range(64, 511));
                  new_top    = 9'($urandom_range(0, 128));
                  new_bottom = 9'($urandom_range(64, 511));
                  new_key    = ($urandom_range(0, 1) == 1) ? 24'($urandom) : 24'h000000;
                  new_pitch  = 9'($urandom_range(0, 511));
               end
            endcase
            // upper data bits of the narrow registers carry junk in the later phases
            junk = (phase >= 3) ? 15'($urandom) : 15'd0;
            write_csr(CSR_CLIP_LEFT, {junk, new_left});
            write_csr(CSR_CLIP_RIGHT, {junk, new_right});
            write_csr(CSR_CLIP_TOP, {junk, new_top});
            write_csr(CSR_CLIP_BOTTOM, {junk, new_bottom});
            write_csr(CSR_COLOR_KEY, new_key);
            write_csr(CSR_SHEET_PITCH, {junk, new_pitch});
            if (phase >= 3) begin
               write_csr(CSR_SPARE_A, 24'($urandom));
               write_csr(CSR_SPARE_B, 24'($urandom));
            end
            csr_valid <= 1'b0;
         end

         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               // sprite job: load a small source block, then draw it scaled
               base  = 16'($urandom);
               src_w = $urandom_range(1, 4);
               src_h = $urandom_range(1, 4);
               for (r = 0; r < src_h; r++)
                  for (c = 0; c < src_w; c++)
                     send_item(load_item(16'(base + r * sheet_pitch + c)), 1'b0, NO_WRITE);
               span_w      = $urandom_range(1, 8);
               span_h      = $urandom_range(1, 8);
               step_x      = 25'((src_w << FRAC_W) / span_w);
               step_y      = 25'((src_h << FRAC_W) / span_h);
               dx0         = $urandom_range(0, 270) - 8;
               dy0         = $urandom_range(0, 270) - 8;
               sprite_flip = 2'($urandom);
               for (oy = 0; oy < span_h; oy++)
                  for (ox = 0; ox < span_w; ox++) begin
                     it = random_fields();
                     it.mode          = MODE_DRAW;
                     it.sheet_addr    = base;
                     it.dest_x        = 12'(dx0 + ox);
                     it.dest_y        = 12'(dy0 + oy);
                     it.offset_x      = 10'(ox);
                     it.offset_y      = 10'(oy);
                     it.scaled_width  = 11'(span_w);
                     it.scaled_height = 11'(span_h);
                     it.x_ratio       = step_x;
                     it.y_ratio       = step_y;
                     it.flip          = sprite_flip;
                     send_draw(it);
                  end
            end else if (pick < 85) begin
               // stray draw with wide-ranging fields
               it = random_fields();
               it.mode = MODE_DRAW;
               if ($urandom_range(0, 3) != 0) begin
                  it.dest_x = 12'($urandom_range(0, 271) - 8);
                  it.dest_y = 12'($urandom_range(0, 271) - 8);
               end
               case ($urandom_range(0, 3))
                  0: ;
                  1: begin
                     it.x_ratio = 25'($urandom_range(0, 'h20000));
                     it.y_ratio = 25'($urandom_range(0, 'h20000));
                  end
                  2: begin
                     it.x_ratio = ($urandom_range(0, 1) == 1) ? MAX_RATIO : 25'h1000000;
                     it.y_ratio = ($urandom_range(0, 1) == 1) ? 25'd0 : 25'd1;
                  end
                  default: begin
                     it.x_ratio = UNIT_RATIO;
                     it.y_ratio = UNIT_RATIO;
                  end
               endcase
               send_draw(it);
            end else begin
               send_item(load_item(16'($urandom)), 1'b0, NO_WRITE);
            end
         end
      end

      // let the pipeline drain, then allow for its depth
      req_valid <= 1'b0;
      while (pixel_writes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS scaled_sprite_blit_pixel");
      end else begin
         $display("FAIL scaled_sprite_blit_pixel");
      end
      $finish;
   end

endmodule

FILE: scaled_sprite_blit_pixel.f
src/ssb_pkg.sv
src/ssb_sheet.sv
src/scaled_sprite_blit_pixel.sv
bench/tb_scaled_sprite_blit_pixel.sv
